### hw/rtl/prlp_pkg.sv
`default_nettype none

package prlp_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int TBL_IDX_W   = $clog2(TABLE_DEPTH);
	localparam int PAGE_BITS   = 32;

	// request codes
	typedef enum logic [1:0] {
		REQ_CHAR  = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_kind_t;

	// register indexes
	localparam logic CFG_MIN_PAGE = 1'b0;
	localparam logic CFG_MAX_PAGE = 1'b1;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	localparam logic signed [PAGE_BITS-1:0] PAGE_MIN = {1'b1, {(PAGE_BITS-1){1'b0}}};
	localparam logic signed [PAGE_BITS-1:0] PAGE_MAX = {1'b0, {(PAGE_BITS-1){1'b1}}};

	typedef struct packed {
		logic [1:0]                  req_type;
		logic [7:0]                  char_code;
		logic signed [PAGE_BITS-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic                        in_list;
		logic                        range_stored;
		logic                        string_done;
		logic                        syntax_error;
		logic                        table_full;
		logic signed [PAGE_BITS-1:0] stored_low;
		logic signed [PAGE_BITS-1:0] stored_high;
	} res_t;

	// range table control and status
	typedef struct packed {
		logic                        clear;
		logic                        put;
		logic signed [PAGE_BITS-1:0] lo;
		logic signed [PAGE_BITS-1:0] hi;
		logic signed [PAGE_BITS-1:0] page;
	} tbl_cmd_t;

	typedef struct packed {
		logic hit;
		logic has_free;
	} tbl_stat_t;

endpackage

`default_nettype wire

### hw/rtl/prlp_table.sv
`default_nettype none

module prlp_table
	import prlp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire tbl_cmd_t  cmd,
	output tbl_stat_t      stat
);

	logic signed [PAGE_BITS-1:0] low_q  [TABLE_DEPTH];
	logic signed [PAGE_BITS-1:0] high_q [TABLE_DEPTH];

	logic [TABLE_DEPTH-1:0] free_vec;
	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [TBL_IDX_W-1:0]   free_idx;
	logic                   found;

	always_comb begin
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			free_vec[k] = low_q[k] > high_q[k];
			hit_vec[k]  = (cmd.page >= low_q[k]) && (cmd.page <= high_q[k]);
		end
	end

	// lowest free slot
	always_comb begin
		found    = 1'b0;
		free_idx = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (!found && free_vec[k]) begin
				found    = 1'b1;
				free_idx = TBL_IDX_W'(k);
			end
		end
	end

	assign stat.hit      = |hit_vec;
	assign stat.has_free = found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				low_q[k]  <= '0;
				high_q[k] <= '1;
			end
		end else if (cmd.clear) begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				low_q[k]  <= '0;
				high_q[k] <= '1;
			end
		end else if (cmd.put && found) begin
			low_q[free_idx]  <= cmd.lo;
			high_q[free_idx] <= cmd.hi;
		end
	end

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (free_vec == '1))
		else $error("table not empty after clear");

	a_hit_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit |-> (free_vec != '1))
		else $error("hit reported on an empty table");

	a_put_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put && found && !cmd.clear) |=>
			(low_q[$past(free_idx)] == $past(cmd.lo)) &&
			(high_q[$past(free_idx)] == $past(cmd.hi)))
		else $error("stored range missing from its slot");

endmodule

`default_nettype wire

### hw/rtl/page_range_list_parser_core.sv
`default_nettype none

// Page-list parser with a 16-entry range table. Each word on req carries a
// string character, a membership query or a table clear, and gives exactly
// one word on res, in order. A word is taken into an input register and is
// handled there against the parser state and the register table (all 16
// slots compared at once), the answer landing in the output register: one
// word per cycle while res is not stalled. A stalled res only holds the word
// in the input register, and req keeps accepting as soon as that register
// moves on. The user must write min_page and max_page via cfg_we/cfg_index/
// cfg_wdata only while no word is in flight; the block does not enforce it.
module page_range_list_parser_core
	import prlp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire req_t                  req,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output res_t                       res,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [PAGE_BITS-1:0]  cfg_wdata
);

	localparam int ACC_W = PAGE_BITS + 4;
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(PAGE_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(PAGE_MIN);

	logic                        valid_s1;
	req_t                        item_s1;
	logic                        res_valid_q;
	res_t                        res_q;
	res_t                        res_d;
	logic                        proc;

	logic signed [PAGE_BITS-1:0] min_q, max_q;

	logic                        gathering_q, seen_mark_q, negative_q, skip_q;
	logic signed [PAGE_BITS-1:0] acc_q, pending_q;
	logic                        gathering_d, seen_mark_d, negative_d, skip_d;
	logic signed [PAGE_BITS-1:0] acc_d, pending_d;

	tbl_cmd_t                    tcmd;
	tbl_stat_t                   tstat;

	logic [7:0]                  c;
	logic                        c_sep, c_digit, c_nul;
	logic signed [ACC_W-1:0]     acc_ext, acc_x10, acc_sum, digit;

	assign proc      = valid_s1 && (!res_valid_q || res_ready);
	assign req_ready = !valid_s1 || proc;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign c       = item_s1.char_code;
	assign c_nul   = c == CH_NUL;
	assign c_sep   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
	assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);

	// saturating decimal accumulate, digit value sits in the low nibble
	assign acc_ext = {{(ACC_W-PAGE_BITS){acc_q[PAGE_BITS-1]}}, acc_q};
	assign acc_x10 = (acc_ext <<< 3) + (acc_ext <<< 1);
	assign digit   = {{(ACC_W-4){1'b0}}, c[3:0]};
	assign acc_sum = negative_q ? acc_x10 - digit : acc_x10 + digit;

	always_comb begin
		gathering_d = gathering_q;
		seen_mark_d = seen_mark_q;
		negative_d  = negative_q;
		skip_d      = skip_q;
		acc_d       = acc_q;
		pending_d   = pending_q;
		res_d       = '0;
		tcmd.clear  = 1'b0;
		tcmd.put    = 1'b0;
		tcmd.lo     = '0;
		tcmd.hi     = '0;
		tcmd.page   = item_s1.page_number;

		case (item_s1.req_type)
			REQ_QUERY: begin
				res_d.in_list = tstat.hit;
			end
			REQ_CLEAR: begin
				tcmd.clear  = 1'b1;
				gathering_d = 1'b0;
				seen_mark_d = 1'b0;
				negative_d  = 1'b0;
				skip_d      = 1'b0;
				acc_d       = '0;
				pending_d   = '0;
			end
			REQ_CHAR: begin
				if (skip_q) begin
					if (c_nul) begin
						gathering_d = 1'b0;
						seen_mark_d = 1'b0;
						negative_d  = 1'b0;
						skip_d      = 1'b0;
						acc_d       = '0;
						pending_d   = '0;
					end
				end else if (!gathering_q && !seen_mark_q && (c_nul || c_sep)) begin
					if (c_nul) begin
						res_d.string_done = 1'b1;
						negative_d        = 1'b0;
						acc_d             = '0;
						pending_d         = '0;
					end
				end else if (c == CH_MINUS && !gathering_q) begin
					gathering_d = 1'b1;
					negative_d  = 1'b1;
					acc_d       = '0;
				end else if (c_digit) begin
					if (!gathering_q) begin
						gathering_d = 1'b1;
						negative_d  = 1'b0;
						acc_d       = PAGE_BITS'(c[3:0]);
					end else if (acc_sum > SAT_HI) begin
						acc_d = PAGE_MAX;
					end else if (acc_sum < SAT_LO) begin
						acc_d = PAGE_MIN;
					end else begin
						acc_d = acc_sum[PAGE_BITS-1:0];
					end
				end else if (c == CH_MINUS || c == CH_COLON) begin
					if (seen_mark_q) begin
						res_d.syntax_error = 1'b1;
						skip_d             = 1'b1;
					end else begin
						pending_d   = gathering_q ? acc_q : min_q;
						seen_mark_d = 1'b1;
						gathering_d = 1'b0;
					end
				end else if (c_nul || c_sep) begin
					// entry complete: store it
					if (!gathering_q) begin
						tcmd.hi = max_q;
						tcmd.lo = seen_mark_q ? pending_q : min_q;
					end else begin
						tcmd.hi = acc_q;
						tcmd.lo = seen_mark_q ? pending_q : acc_q;
					end
					tcmd.put           = 1'b1;
					res_d.stored_low   = tcmd.lo;
					res_d.stored_high  = tcmd.hi;
					res_d.range_stored = tstat.has_free;
					res_d.table_full   = !tstat.has_free;
					gathering_d        = 1'b0;
					seen_mark_d        = 1'b0;
					if (c_nul) begin
						res_d.string_done = 1'b1;
						negative_d        = 1'b0;
						skip_d            = 1'b0;
						acc_d             = '0;
						pending_d         = '0;
					end
				end else begin
					res_d.syntax_error = 1'b1;
					skip_d             = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (!proc) begin
			tcmd.clear = 1'b0;
			tcmd.put   = 1'b0;
		end
	end

	prlp_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (tcmd),
		.stat   (tstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			min_q       <= PAGE_MIN;
			max_q       <= PAGE_MAX;
			gathering_q <= 1'b0;
			seen_mark_q <= 1'b0;
			negative_q  <= 1'b0;
			skip_q      <= 1'b0;
			acc_q       <= '0;
			pending_q   <= '0;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (proc) begin
				valid_s1 <= 1'b0;
			end
			if (proc) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_PAGE: min_q <= cfg_wdata;
					CFG_MAX_PAGE: max_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (proc) begin
				gathering_q <= gathering_d;
				seen_mark_q <= seen_mark_d;
				negative_q  <= negative_d;
				skip_q      <= skip_d;
				acc_q       <= acc_d;
				pending_q   <= pending_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
		if (proc) begin
			res_q <= res_d;
		end
	end

	a_skip_from_error: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skip_q) |-> $past(proc && res_d.syntax_error))
		else $error("skip mode entered without a syntax error");

	a_stored_or_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.range_stored && res_q.table_full))
		else $error("range both stored and dropped");

	a_answer_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(proc && res_d.in_list) |-> (item_s1.req_type == REQ_QUERY))
		else $error("in_list raised on a non-query word");

	a_no_put_and_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(tcmd.put && tcmd.clear))
		else $error("table put and clear at once");

endmodule

`default_nettype wire

### verif/prlp_result_check.sv
module prlp_result_check
	import prlp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	input  wire logic                 req_ready,
	input  wire req_t                 req,
	input  wire logic                 res_valid,
	input  wire logic                 res_ready,
	input  wire res_t                 res,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [PAGE_BITS-1:0] cfg_wdata,
	output int                        errors,
	output int                        pending
);

	localparam int PRINT_CAP = 100;

	logic signed [PAGE_BITS-1:0] min_pg;
	logic signed [PAGE_BITS-1:0] max_pg;

	logic                        gathering;
	logic                        range_mark;
	logic                        negative;
	logic                        skipping;
	logic signed [PAGE_BITS-1:0] acc;
	logic signed [PAGE_BITS-1:0] pend_low;
	logic signed [PAGE_BITS-1:0] lo_tab [TABLE_DEPTH];
	logic signed [PAGE_BITS-1:0] hi_tab [TABLE_DEPTH];

	res_t parse_answers_q [$];
	res_t want;
	int   res_seen;

	function automatic void reset_parser();
		gathering  = 1'b0;
		range_mark = 1'b0;
		negative   = 1'b0;
		skipping   = 1'b0;
		acc        = '0;
		pend_low   = '0;
	endfunction

	function automatic void empty_table();
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			lo_tab[k] = '0;
			hi_tab[k] = '1;
		end
	endfunction

	// first slot with low above high is free
	function automatic bit store_range(input logic signed [PAGE_BITS-1:0] lo,
			input logic signed [PAGE_BITS-1:0] hi);
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (lo_tab[k] > hi_tab[k]) begin
				lo_tab[k] = lo;
				hi_tab[k] = hi;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic parse_page_word(input req_t w, output res_t r);
		logic signed [PAGE_BITS-1:0] pg;
		logic signed [PAGE_BITS-1:0] lo;
		logic signed [PAGE_BITS-1:0] hi;
		logic [7:0]                  c;
		logic                        sep;
		longint                      v;
		int                          d;
		r   = '0;
		pg  = w.page_number;
		c   = w.char_code;
		sep = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_COMMA);
		case (w.req_type)
			REQ_QUERY: begin
				for (int k = 0; k < TABLE_DEPTH; k++) begin
					if (pg >= lo_tab[k] && pg <= hi_tab[k])
						r.in_list = 1'b1;
				end
			end
			REQ_CLEAR: begin
				empty_table();
				reset_parser();
			end
			REQ_CHAR: begin
				if (skipping) begin
					if (c == CH_NUL)
						reset_parser();
				end else if (!gathering && !range_mark && (c == CH_NUL || sep)) begin
					if (c == CH_NUL) begin
						r.string_done = 1'b1;
						reset_parser();
					end
				end else if (c == CH_MINUS && !gathering) begin
					// sign of a new number, even right after a range mark
					gathering = 1'b1;
					negative  = 1'b1;
					acc       = '0;
				end else if (c >= CH_ZERO && c <= CH_NINE) begin
					d = int'(c) - int'(CH_ZERO);
					if (!gathering) begin
						gathering = 1'b1;
						negative  = 1'b0;
						acc       = d;
					end else begin
						v = longint'(acc) * 10;
						v = negative ? v - d : v + d;
						if (v > longint'(PAGE_MAX))
							v = longint'(PAGE_MAX);
						if (v < longint'(PAGE_MIN))
							v = longint'(PAGE_MIN);
						acc = v[PAGE_BITS-1:0];
					end
				end else if (c == CH_MINUS || c == CH_COLON) begin
					if (range_mark) begin
						r.syntax_error = 1'b1;
						skipping       = 1'b1;
					end else begin
						pend_low   = gathering ? acc : min_pg;
						range_mark = 1'b1;
						gathering  = 1'b0;
					end
				end else if (c == CH_NUL || sep) begin
					if (!gathering) begin
						hi = max_pg;
						lo = range_mark ? pend_low : min_pg;
					end else begin
						hi = acc;
						lo = range_mark ? pend_low : acc;
					end
					if (store_range(lo, hi))
						r.range_stored = 1'b1;
					else
						r.table_full = 1'b1;
					r.stored_low  = lo;
					r.stored_high = hi;
					if (c == CH_NUL) begin
						r.string_done = 1'b1;
						reset_parser();
					end else begin
						range_mark = 1'b0;
						gathering  = 1'b0;
					end
				end else begin
					r.syntax_error = 1'b1;
					skipping       = 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_error(input string msg);
		if (errors < PRINT_CAP)
			$display("ERROR: %s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input longint got, input longint exp_val);
		if (got != exp_val)
			report_error($sformatf("result %0d %s: got %0d, want %0d",
				res_seen, name, got, exp_val));
	endtask

	task automatic compare_word(input res_t got, input res_t exp_w);
		check_field("in_list", got.in_list, exp_w.in_list);
		check_field("range_stored", got.range_stored, exp_w.range_stored);
		check_field("string_done", got.string_done, exp_w.string_done);
		check_field("syntax_error", got.syntax_error, exp_w.syntax_error);
		check_field("table_full", got.table_full, exp_w.table_full);
		check_field("stored_low", $signed(got.stored_low), $signed(exp_w.stored_low));
		check_field("stored_high", $signed(got.stored_high), $signed(exp_w.stored_high));
	endtask

	initial begin
		errors   = 0;
		res_seen = 0;
		min_pg   = PAGE_MIN;
		max_pg   = PAGE_MAX;
		reset_parser();
		empty_table();
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			min_pg = PAGE_MIN;
			max_pg = PAGE_MAX;
			reset_parser();
			empty_table();
			parse_answers_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_PAGE)
					min_pg = cfg_wdata;
				else
					max_pg = cfg_wdata;
			end
			// result first: a word accepted now cannot answer at the same edge
			if (res_valid && res_ready) begin
				if (parse_answers_q.size() == 0) begin
					report_error($sformatf("result %0d arrived with nothing expected",
						res_seen));
				end else begin
					want = parse_answers_q.pop_front();
					compare_word(res, want);
				end
				res_seen++;
			end
			if (req_valid && req_ready) begin
				parse_page_word(req, want);
				parse_answers_q.push_back(want);
			end
		end
		pending <= parse_answers_q.size();
	end

endmodule

### verif/page_range_list_parser_core_tb.sv
module page_range_list_parser_core_tb;
	import prlp_pkg::*;

	localparam logic [1:0] REQ_UNUSED     = 2'd3;
	localparam int         WATCHDOG_LIMIT = 5000;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         PHASE_WORDS    = 500;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req       = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_t                 res;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = CFG_MIN_PAGE;
	logic [PAGE_BITS-1:0] cfg_wdata = '0;

	int chk_errors;
	int chk_pending;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_rx     = 1'b0;
	int items_sent  = 0;
	int stall_cycles;
	int phase_end;
	bit hold_done;
	bit drain_done;

	page_range_list_parser_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	prlp_result_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (chk_errors),
		.pending   (chk_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end else begin
				res_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_word(input logic [1:0] kind, input logic [7:0] c,
			input logic [PAGE_BITS-1:0] pg);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid       <= 1'b1;
		req.req_type    <= kind;
		req.char_code   <= c;
		req.page_number <= pg;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (kind != REQ_UNUSED)
			items_sent++;
	endtask

	task automatic send_char(input logic [7:0] c);
		send_word(REQ_CHAR, c, $urandom());
	endtask

	function automatic logic [PAGE_BITS-1:0] query_page();
		case ($urandom_range(9))
			0:       return PAGE_MIN;
			1:       return PAGE_MAX;
			2, 3:    return $urandom();
			default: return int'($urandom_range(80)) - 40;
		endcase
	endfunction

	task automatic send_text(input string s, input bit noisy);
		for (int i = 0; i < s.len(); i++) begin
			// stray words inside a string: any byte, or a query
			if (noisy && $urandom_range(19) == 0) begin
				if ($urandom_range(1))
					send_word(REQ_QUERY, 8'($urandom_range(255)), query_page());
				else
					send_char(8'($urandom_range(255)));
			end
			send_char(s[i]);
		end
	endtask

	function automatic string number_text();
		string s;
		int    kind;
		s    = "";
		kind = $urandom_range(9);
		if (kind < 6)
			s = $sformatf("%0d", $urandom_range(30));
		else if (kind < 8)
			s = $sformatf("%0d", $urandom_range(32'h7fff_ffff));
		else
			// long enough that it can saturate
			repeat ($urandom_range(12, 10)) s = {s, $sformatf("%0d", $urandom_range(9))};
		if ($urandom_range(9) < 3)
			s = {"-", s};
		return s;
	endfunction

	function automatic string entry_text();
		string a;
		string b;
		string c2;
		a  = number_text();
		b  = number_text();
		c2 = number_text();
		case ($urandom_range(9))
			0, 1:    return a;
			2, 3:    return {a, "-", b};
			4:       return {a, ":", b};
			5:       return {":", b};
			6:       return {a, "-"};
			7:       return ":";
			8:       return "-";
			default: return $urandom_range(1) ? {a, "-", b, ":", c2} : {a, "::"};
		endcase
	endfunction

	function automatic string sep_text();
		case ($urandom_range(2))
			0:       return " ";
			1:       return "\t";
			default: return ",";
		endcase
	endfunction

	task automatic send_page_list();
		string s;
		int    n;
		s = "";
		n = $urandom_range(4);
		for (int i = 0; i < n; i++) begin
			s = {s, entry_text()};
			if (i < n - 1 || $urandom_range(1))
				s = {s, sep_text()};
			if ($urandom_range(3) == 0)
				s = {s, sep_text()};
		end
		send_text(s, 1'b1);
		send_char(CH_NUL);
	endtask

	task automatic wait_results_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0)
			@(posedge clk);
	endtask

	task automatic set_page_bounds(input logic [PAGE_BITS-1:0] lo,
			input logic [PAGE_BITS-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_PAGE;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= CFG_MAX_PAGE;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words
		set_page_bounds(-20, 40);
		tx_idle_pct = 13;
		rx_idle_pct = 73;
		send_text("3--5\t:2,", 1'b0);
		send_char(CH_NUL);
		send_word(REQ_QUERY, CH_NUL, 0);
		send_word(REQ_QUERY, CH_NINE, PAGE_MAX);
		send_text("7x", 1'b0);
		send_char(CH_NUL);
		send_text("1::", 1'b0);
		send_char(CH_NUL);
		send_word(REQ_UNUSED, 8'($urandom_range(255)), $urandom());
		send_word(REQ_CLEAR, CH_ZERO, $urandom());
		send_word(REQ_QUERY, CH_NUL, 0);
		send_char(CH_NUL);
		wait_results_drained();

		hold_done  = 1'b0;
		drain_done = 1'b0;
		phase_end  = items_sent;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 13;
					rx_idle_pct = 73;
					set_page_bounds(PAGE_MIN, PAGE_MAX);
				end
				1: begin
					tx_idle_pct = 73;
					rx_idle_pct = 13;
					set_page_bounds(-50, 50);
				end
				2: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					// missing bounds now give inverted ranges
					set_page_bounds(PAGE_MAX, PAGE_MIN);
				end
				default: begin
					set_page_bounds($urandom(), $urandom());
				end
			endcase
			phase_end += PHASE_WORDS;
			while (items_sent < phase_end) begin
				if (!hold_done && items_sent > phase_end - PHASE_WORDS + 150) begin
					hold_rx   = 1'b1;
					hold_done = 1'b1;
				end
				if (phase == 1 && !drain_done && items_sent > phase_end - 250) begin
					wait_results_drained();
					drain_done = 1'b1;
				end
				send_page_list();
				repeat ($urandom_range(3))
					send_word(REQ_QUERY, 8'($urandom_range(255)), query_page());
				if ($urandom_range(11) == 0)
					send_word(REQ_CLEAR, 8'($urandom_range(255)), $urandom());
				if ($urandom_range(39) == 0)
					send_word(REQ_UNUSED, 8'($urandom_range(255)), $urandom());
			end
			wait_results_drained();
		end

		repeat (10) @(posedge clk);
		if (chk_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
